// ===== src/sbpa_pkg.sv =====
// shared types and constants of the segmented block pool allocator
`default_nettype none

package sbpa_pkg;

   // field widths of the item, result and register ports
   localparam int FUNC_W     = 2;
   localparam int BLOCK_W    = 8;
   localparam int SIZE_W     = 16;
   localparam int STATUS_W   = 2;
   localparam int CFG_W      = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_REINIT = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SEGMENTS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SEGMENTS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BYTES  = 2'd2;

   // register reset values
   localparam logic [CFG_W-1:0]  MIN_SEGMENTS_RESET = 5'd1;
   localparam logic [CFG_W-1:0]  MAX_SEGMENTS_RESET = 5'd0;
   localparam logic [SIZE_W-1:0] BLOCK_BYTES_RESET  = 16'd64;

   // fraction bits of the reciprocal used to split a block number
   localparam int RECIP_SHIFT = 16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SPLIT,
      ST_LOCATE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic wr_full;
      logic clr_all;
      logic clr_row;
   } mem_ctl_type;

endpackage

`default_nettype wire

// ===== src/sbpa_slot_mem.sv =====
// slot catalog memory with per-entry valid bits and a registered read
`default_nettype none

module sbpa_slot_mem #(
   parameter int BLOCKS_PER_SEGMENT = 16,
   parameter int SEGMENT_SLOTS      = 16
) (
   input  wire                                          clock,
   input  wire                                          reset,
   input  wire sbpa_pkg::mem_ctl_type                   ctl,
   input  wire [((SEGMENT_SLOTS > 1) ? $clog2(SEGMENT_SLOTS) : 1)-1:0]           rd_seg,
   input  wire [((BLOCKS_PER_SEGMENT > 1) ? $clog2(BLOCKS_PER_SEGMENT) : 1)-1:0] rd_slot,
   input  wire [((SEGMENT_SLOTS > 1) ? $clog2(SEGMENT_SLOTS) : 1)-1:0]           wr_seg,
   input  wire [((BLOCKS_PER_SEGMENT > 1) ? $clog2(BLOCKS_PER_SEGMENT) : 1)-1:0] wr_slot,
   input  wire [((BLOCKS_PER_SEGMENT > 1) ? $clog2(BLOCKS_PER_SEGMENT) : 1)-1:0] wr_off,
   input  wire [((SEGMENT_SLOTS > 1) ? $clog2(SEGMENT_SLOTS) : 1)-1:0]           clr_seg,
   output logic                                         rd_full,
   output logic [((BLOCKS_PER_SEGMENT > 1) ? $clog2(BLOCKS_PER_SEGMENT) : 1)-1:0] rd_off
);

   localparam int SLOT_W  = (BLOCKS_PER_SEGMENT > 1) ? $clog2(BLOCKS_PER_SEGMENT) : 1;
   localparam int SEG_W   = (SEGMENT_SLOTS > 1) ? $clog2(SEGMENT_SLOTS) : 1;
   localparam int ENTRIES = SEGMENT_SLOTS * BLOCKS_PER_SEGMENT;
   localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic [SLOT_W:0]      store_mem [0:ENTRIES-1];
   logic [ENTRIES-1:0]   valid_ff;
   logic [ENTRIES-1:0]   valid_in;
   logic [ADDR_W-1:0]    rd_addr;
   logic [ADDR_W-1:0]    wr_addr;
   logic [SLOT_W:0]      rd_word_ff;
   logic                 rd_valid_ff;
   logic [SLOT_W-1:0]    rd_slot_ff;

   assign rd_addr = ADDR_W'(int'(rd_seg) * BLOCKS_PER_SEGMENT + int'(rd_slot));
   assign wr_addr = ADDR_W'(int'(wr_seg) * BLOCKS_PER_SEGMENT + int'(wr_slot));

   // a cleared entry reads as full, holding its own offset
   always_comb begin
      valid_in = valid_ff;
      if (ctl.clr_all) begin
         valid_in = '0;
      end
      if (ctl.clr_row) begin
         for (int r = 0; r < SEGMENT_SLOTS; r++) begin
            if (SEG_W'(r) == clr_seg) begin
               valid_in[r*BLOCKS_PER_SEGMENT +: BLOCKS_PER_SEGMENT] = '0;
            end
         end
      end
      if (ctl.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store_mem[wr_addr] <= {ctl.wr_full, wr_off};
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_word_ff  <= store_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
         rd_slot_ff  <= rd_slot;
      end
   end

   assign rd_full = rd_valid_ff ? rd_word_ff[SLOT_W] : 1'b1;
   assign rd_off  = rd_valid_ff ? rd_word_ff[SLOT_W-1:0] : rd_slot_ff;

endmodule

`default_nettype wire

// ===== src/segmented_block_pool_allocator_core.sv =====
// top level of the segmented fixed-size block pool allocator
// steps: reinitialize and unused codes answer from the idle state; free splits the block
//   number, locates its segment (an out-of-range block answers there) and scans that segment;
//   allocate scans from the current segment to the last active one; a scan reads one slot per cycle
// throughput: one item at a time, the next taken in the cycle its result shows; the
//   result strobe lasts one cycle and is never held off; reset: pool as after reinitialize
`default_nettype none

module segmented_block_pool_allocator_core #(
   parameter int BLOCKS_PER_SEGMENT = 16,
   parameter int SEGMENT_SLOTS      = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   // item channel
   input  wire                                start,
   output logic                               busy,
   input  wire [sbpa_pkg::FUNC_W-1:0]         req_func,
   input  wire [sbpa_pkg::BLOCK_W-1:0]        req_block_id,
   // result channel
   output logic                               rsp_valid,
   output logic [sbpa_pkg::STATUS_W-1:0]      rsp_status,
   output logic [sbpa_pkg::BLOCK_W-1:0]       rsp_granted_block,
   output logic [sbpa_pkg::SIZE_W-1:0]        rsp_granted_size,
   output logic                               rsp_all_free,
   // register write channel
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire [sbpa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [sbpa_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int SLOT_W   = (BLOCKS_PER_SEGMENT > 1) ? $clog2(BLOCKS_PER_SEGMENT) : 1;
   localparam int SEG_W    = (SEGMENT_SLOTS > 1) ? $clog2(SEGMENT_SLOTS) : 1;
   localparam int CNT_W    = $clog2(SEGMENT_SLOTS + 1);
   localparam int CMP_W    = (CNT_W > sbpa_pkg::CFG_W) ? CNT_W : sbpa_pkg::CFG_W;
   localparam int ID_CMP_W = (CNT_W > sbpa_pkg::BLOCK_W) ? CNT_W : sbpa_pkg::BLOCK_W;
   localparam int EMPTY_W  = $clog2(SEGMENT_SLOTS * BLOCKS_PER_SEGMENT + 1);
   // reciprocal of the segment size, exact for every 8-bit block number
   localparam int RECIP    = (2 ** sbpa_pkg::RECIP_SHIFT + BLOCKS_PER_SEGMENT - 1)
                             / BLOCKS_PER_SEGMENT;
   localparam int PROD_W   = sbpa_pkg::BLOCK_W + sbpa_pkg::RECIP_SHIFT + 1;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(BLOCKS_PER_SEGMENT - 1);
   localparam logic [CMP_W-1:0]  SEGS_CMP  = CMP_W'(SEGMENT_SLOTS);

   // control state
   sbpa_pkg::state_type state_ff, state_in;
   logic [sbpa_pkg::CFG_W-1:0]   min_seg_ff, min_seg_in;
   logic [sbpa_pkg::CFG_W-1:0]   max_seg_ff, max_seg_in;
   logic [sbpa_pkg::SIZE_W-1:0]  block_bytes_ff, block_bytes_in;
   logic [CNT_W-1:0]             active_ff, active_in;
   logic [SEG_W-1:0]             current_ff, current_in;
   logic [EMPTY_W-1:0]           empty_ff, empty_in;
   logic                         iss_live_ff, iss_live_in;
   logic                         chk_valid_ff, chk_valid_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // item and scan payload
   logic [sbpa_pkg::BLOCK_W-1:0] id_ff, id_in;
   logic [sbpa_pkg::BLOCK_W-1:0] quot_ff, quot_in;
   logic [SLOT_W-1:0]            off_ff, off_in;
   logic [SEG_W-1:0]             end_seg_ff, end_seg_in;
   logic                         want_full_ff, want_full_in;
   logic [SEG_W-1:0]             iss_seg_ff, iss_seg_in;
   logic [SLOT_W-1:0]            iss_slot_ff, iss_slot_in;
   logic [SEG_W-1:0]             chk_seg_ff, chk_seg_in;
   logic [SLOT_W-1:0]            chk_slot_ff, chk_slot_in;

   // result payload
   logic [sbpa_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [sbpa_pkg::BLOCK_W-1:0]  rsp_block_ff, rsp_block_in;
   logic [sbpa_pkg::SIZE_W-1:0]   rsp_size_ff, rsp_size_in;
   logic                          rsp_all_free_ff, rsp_all_free_in;

   // combinational helpers
   logic                          accept;
   logic                          cfg_we;
   logic [CMP_W-1:0]              min_ext, max_ext, lim_ext;
   logic [CNT_W-1:0]              eff_min, limit;
   logic                          can_open;
   logic [PROD_W-1:0]             quot_prod;
   logic [sbpa_pkg::BLOCK_W-1:0]  quot_calc;
   logic [SLOT_W-1:0]             id_off;
   logic                          in_range;
   logic                          hit, miss, finish;
   logic [SEG_W-1:0]              free_cur;
   logic [sbpa_pkg::BLOCK_W-1:0]  grant_hit, grant_open;

   // memory interface
   sbpa_pkg::mem_ctl_type         mem_ctl;
   logic [SEG_W-1:0]              wr_seg, clr_seg;
   logic [SLOT_W-1:0]             wr_slot, wr_off;
   logic                          rd_full;
   logic [SLOT_W-1:0]             rd_off;

   // ---------------------------------------------------------------- registers
   // always ready: the user must write only while the pool is idle; the block itself does not enforce it
   assign csr_ready = 1'b1;
   assign cfg_we    = csr_valid & csr_ready;

   always_comb begin
      min_seg_in     = min_seg_ff;
      max_seg_in     = max_seg_ff;
      block_bytes_in = block_bytes_ff;
      if (cfg_we) begin
         case (csr_index)
            sbpa_pkg::CSR_MIN_SEGMENTS: min_seg_in     = csr_data[sbpa_pkg::CFG_W-1:0];
            sbpa_pkg::CSR_MAX_SEGMENTS: max_seg_in     = csr_data[sbpa_pkg::CFG_W-1:0];
            sbpa_pkg::CSR_BLOCK_BYTES:  block_bytes_in = csr_data;
            default: ;
         endcase
      end
   end

   // effective minimum clamps to 1..segments, limit to minimum..segments
   always_comb begin
      min_ext = CMP_W'(min_seg_ff);
      if (min_ext == '0) begin
         min_ext = CMP_W'(1);
      end else if (min_ext > SEGS_CMP) begin
         min_ext = SEGS_CMP;
      end
      max_ext = CMP_W'(max_seg_ff);
      if (max_ext == '0) begin
         lim_ext = SEGS_CMP;
      end else begin
         lim_ext = (max_ext < min_ext) ? min_ext : max_ext;
         if (lim_ext > SEGS_CMP) begin
            lim_ext = SEGS_CMP;
         end
      end
      eff_min = CNT_W'(min_ext);
      limit   = CNT_W'(lim_ext);
   end

   assign can_open = active_ff < limit;

   // ---------------------------------------------------------------- block split
   // segment of a freed block by reciprocal multiply, offset from the registered segment in the cycle after
   assign quot_prod = PROD_W'(id_ff) * PROD_W'(RECIP);
   assign quot_calc = sbpa_pkg::BLOCK_W'(quot_prod >> sbpa_pkg::RECIP_SHIFT);
   assign id_off    = SLOT_W'(int'(id_ff) - int'(quot_ff) * BLOCKS_PER_SEGMENT);
   assign in_range  = ID_CMP_W'(quot_ff) < ID_CMP_W'(active_ff);

   // ---------------------------------------------------------------- scan check
   // allocate looks for a full slot, free for an empty one
   assign hit      = chk_valid_ff & (rd_full == want_full_ff);
   assign miss     = chk_valid_ff & ~hit & (chk_slot_ff == LAST_SLOT)
                     & (chk_seg_ff == end_seg_ff);
   assign finish   = hit | miss;
   assign free_cur = (end_seg_ff < current_ff) ? end_seg_ff : current_ff;
   assign grant_hit  = sbpa_pkg::BLOCK_W'(int'(chk_seg_ff) * BLOCKS_PER_SEGMENT
                                          + int'(rd_off));
   assign grant_open = sbpa_pkg::BLOCK_W'(int'(active_ff) * BLOCKS_PER_SEGMENT);

   assign accept = start & (state_ff == sbpa_pkg::ST_IDLE);

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sbpa_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_func == sbpa_pkg::FUNC_ALLOC) begin
                  state_in = sbpa_pkg::ST_SCAN;
               end else if (req_func == sbpa_pkg::FUNC_FREE) begin
                  state_in = sbpa_pkg::ST_SPLIT;
               end
            end
         end
         sbpa_pkg::ST_SPLIT: state_in = sbpa_pkg::ST_LOCATE;
         sbpa_pkg::ST_LOCATE: begin
            state_in = in_range ? sbpa_pkg::ST_SCAN : sbpa_pkg::ST_IDLE;
         end
         sbpa_pkg::ST_SCAN: begin
            if (finish) begin
               state_in = sbpa_pkg::ST_IDLE;
            end
         end
         default: state_in = sbpa_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- fsm outputs
   // the memory sees one access pattern per state, so the read of a slot never
   // meets a write to it: every slot write ends the scan, and the next item's
   // first read comes only after a pass through the idle state
   always_comb begin
      busy    = state_ff != sbpa_pkg::ST_IDLE;
      mem_ctl = '0;
      wr_seg  = chk_seg_ff;
      wr_slot = chk_slot_ff;
      wr_off  = rd_off;
      clr_seg = SEG_W'(active_ff);
      case (state_ff)
         sbpa_pkg::ST_IDLE: begin
            mem_ctl.clr_all = accept & (req_func == sbpa_pkg::FUNC_REINIT);
         end
         sbpa_pkg::ST_SCAN: begin
            mem_ctl.rd_en = iss_live_ff;
            if (hit) begin
               // allocate empties the slot, free stores its offset
               mem_ctl.wr_en   = 1'b1;
               mem_ctl.wr_full = ~want_full_ff;
               wr_off          = want_full_ff ? rd_off : off_ff;
            end else if (miss && want_full_ff && can_open) begin
               // open the next segment fresh and take its first slot
               mem_ctl.clr_row = 1'b1;
               mem_ctl.wr_en   = 1'b1;
               mem_ctl.wr_full = 1'b0;
               wr_seg          = SEG_W'(active_ff);
               wr_slot         = '0;
               wr_off          = '0;
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      active_in       = active_ff;
      current_in      = current_ff;
      empty_in        = empty_ff;
      id_in           = id_ff;
      quot_in         = quot_ff;
      off_in          = off_ff;
      end_seg_in      = end_seg_ff;
      want_full_in    = want_full_ff;
      iss_seg_in      = iss_seg_ff;
      iss_slot_in     = iss_slot_ff;
      iss_live_in     = iss_live_ff;
      chk_seg_in      = iss_seg_ff;
      chk_slot_in     = iss_slot_ff;
      chk_valid_in    = 1'b0;
      rsp_valid_in    = 1'b0;
      rsp_status_in   = sbpa_pkg::STATUS_OK;
      rsp_block_in    = '0;
      rsp_size_in     = '0;
      case (state_ff)
         sbpa_pkg::ST_IDLE: begin
            if (accept) begin
               id_in = req_block_id;
               if (req_func == sbpa_pkg::FUNC_ALLOC) begin
                  // scan from the current segment to the last active one
                  iss_seg_in   = current_ff;
                  iss_slot_in  = '0;
                  iss_live_in  = 1'b1;
                  end_seg_in   = SEG_W'(active_ff - CNT_W'(1));
                  want_full_in = 1'b1;
               end else if (req_func == sbpa_pkg::FUNC_REINIT) begin
                  active_in    = eff_min;
                  current_in   = '0;
                  empty_in     = '0;
                  rsp_valid_in = 1'b1;
               end else if (req_func != sbpa_pkg::FUNC_FREE) begin
                  // unused code answers at once with nothing changed
                  rsp_valid_in = 1'b1;
               end
            end
         end
         sbpa_pkg::ST_SPLIT: begin
            quot_in = quot_calc;
         end
         sbpa_pkg::ST_LOCATE: begin
            if (in_range) begin
               // scan the catalog of the block's own segment
               off_in       = id_off;
               end_seg_in   = SEG_W'(quot_ff);
               iss_seg_in   = SEG_W'(quot_ff);
               iss_slot_in  = '0;
               iss_live_in  = 1'b1;
               want_full_in = 1'b0;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = sbpa_pkg::STATUS_RANGE;
            end
         end
         sbpa_pkg::ST_SCAN: begin
            chk_valid_in = iss_live_ff & ~finish;
            // read pointer runs one slot ahead of the check
            if (iss_live_ff) begin
               if (iss_slot_ff == LAST_SLOT) begin
                  iss_slot_in = '0;
                  if (iss_seg_ff == end_seg_ff) begin
                     iss_live_in = 1'b0;
                  end else begin
                     iss_seg_in = iss_seg_ff + SEG_W'(1);
                  end
               end else begin
                  iss_slot_in = iss_slot_ff + SLOT_W'(1);
               end
            end
            if (hit) begin
               rsp_valid_in = 1'b1;
               if (want_full_ff) begin
                  current_in   = chk_seg_ff;
                  empty_in     = empty_ff + EMPTY_W'(1);
                  rsp_block_in = grant_hit;
                  rsp_size_in  = block_bytes_ff;
               end else begin
                  current_in = free_cur;
                  empty_in   = empty_ff - EMPTY_W'(1);
               end
            end else if (miss) begin
               rsp_valid_in = 1'b1;
               if (want_full_ff) begin
                  if (can_open) begin
                     active_in    = active_ff + CNT_W'(1);
                     current_in   = SEG_W'(active_ff);
                     empty_in     = empty_ff + EMPTY_W'(1);
                     rsp_block_in = grant_open;
                     rsp_size_in  = block_bytes_ff;
                  end else begin
                     current_in    = end_seg_ff;
                     rsp_status_in = sbpa_pkg::STATUS_EMPTY;
                  end
               end else begin
                  // full catalog: block dropped, still reported as freed
                  current_in = free_cur;
               end
            end
         end
         default: ;
      endcase
      // all free means no empty slot among the active segments
      rsp_all_free_in = empty_in == '0;
   end

   // ---------------------------------------------------------------- flops
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= sbpa_pkg::ST_IDLE;
         min_seg_ff     <= sbpa_pkg::MIN_SEGMENTS_RESET;
         max_seg_ff     <= sbpa_pkg::MAX_SEGMENTS_RESET;
         block_bytes_ff <= sbpa_pkg::BLOCK_BYTES_RESET;
         active_ff      <= CNT_W'(1);
         current_ff     <= '0;
         empty_ff       <= '0;
         iss_live_ff    <= 1'b0;
         chk_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         min_seg_ff     <= min_seg_in;
         max_seg_ff     <= max_seg_in;
         block_bytes_ff <= block_bytes_in;
         active_ff      <= active_in;
         current_ff     <= current_in;
         empty_ff       <= empty_in;
         iss_live_ff    <= iss_live_in;
         chk_valid_ff   <= chk_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff        <= id_in;
      quot_ff      <= quot_in;
      off_ff       <= off_in;
      end_seg_ff   <= end_seg_in;
      want_full_ff <= want_full_in;
      iss_seg_ff   <= iss_seg_in;
      iss_slot_ff  <= iss_slot_in;
      chk_seg_ff   <= chk_seg_in;
      chk_slot_ff  <= chk_slot_in;
      if (rsp_valid_in) begin
         rsp_status_ff   <= rsp_status_in;
         rsp_block_ff    <= rsp_block_in;
         rsp_size_ff     <= rsp_size_in;
         rsp_all_free_ff <= rsp_all_free_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_block = rsp_block_ff;
   assign rsp_granted_size  = rsp_size_ff;
   assign rsp_all_free      = rsp_all_free_ff;

   // ---------------------------------------------------------------- slot memory
   sbpa_slot_mem #(
      .BLOCKS_PER_SEGMENT (BLOCKS_PER_SEGMENT),
      .SEGMENT_SLOTS      (SEGMENT_SLOTS)
   ) u_slot_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .rd_seg  (iss_seg_ff),
      .rd_slot (iss_slot_ff),
      .wr_seg  (wr_seg),
      .wr_slot (wr_slot),
      .wr_off  (wr_off),
      .clr_seg (clr_seg),
      .rd_full (rd_full),
      .rd_off  (rd_off)
   );

   // ---------------------------------------------------------------- checks
   a_current_active: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(current_ff) < active_ff)
      else $error("current segment beyond the active segments");

   a_active_bounds: assert property (@(posedge clock) disable iff (reset)
      active_ff != '0 && CMP_W'(active_ff) <= SEGS_CMP)
      else $error("active segment count out of bounds");

   a_empty_bound: assert property (@(posedge clock) disable iff (reset)
      32'(empty_ff) <= 32'(active_ff) * 32'(BLOCKS_PER_SEGMENT))
      else $error("empty slot count exceeds active slots");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(accept) || $past(state_ff == sbpa_pkg::ST_LOCATE)
                       || $past(state_ff == sbpa_pkg::ST_SCAN))
      else $error("result without an item in progress");

   a_check_in_scan: assert property (@(posedge clock) disable iff (reset)
      chk_valid_ff |-> state_ff == sbpa_pkg::ST_SCAN)
      else $error("slot check outside a scan");

endmodule

`default_nettype wire
